>>> hdl/vmifd_pkg.sv
package vmifd_pkg;

   localparam int ARENA_BYTES = 4096;
   localparam int PC_W        = $clog2(ARENA_BYTES);
   localparam int WIN_BYTES   = 18;
   localparam int WIN_W       = WIN_BYTES * 8;
   localparam int OFF_W       = $clog2(WIN_BYTES + 4);
   localparam int SZ_W        = 3;
   localparam int NUM_PARAMS  = 4;

   localparam logic [7:0] OP_LIVE  = 8'd1;
   localparam logic [7:0] OP_ZJMP  = 8'd9;
   localparam logic [7:0] OP_LDI   = 8'd10;
   localparam logic [7:0] OP_STI   = 8'd11;
   localparam logic [7:0] OP_FORK  = 8'd12;
   localparam logic [7:0] OP_LFORK = 8'd15;
   localparam logic [7:0] OP_LAST  = 8'd16;

   localparam logic [1:0] PAIR_NONE = 2'b00;
   localparam logic [1:0] PAIR_REG  = 2'b01;
   localparam logic [1:0] PAIR_DIR  = 2'b10;
   localparam logic [1:0] PAIR_IND  = 2'b11;

   localparam logic [SZ_W-1:0] SZ_NONE  = SZ_W'(0);
   localparam logic [SZ_W-1:0] SZ_BYTE  = SZ_W'(1);
   localparam logic [SZ_W-1:0] SZ_HALF  = SZ_W'(2);
   localparam logic [SZ_W-1:0] SZ_WORD  = SZ_W'(4);

   typedef enum logic [1:0] {
      CLS_INVALID,
      CLS_LIVE,
      CLS_SHORT,
      CLS_CODED
   } op_class_type;

   typedef struct packed {
      logic [NUM_PARAMS-1:0][OFF_W-1:0] off;
      logic [NUM_PARAMS-1:0][SZ_W-1:0]  sz;
      logic [OFF_W-1:0]                 len;
      logic [7:0]                       type_byte;
   } layout_type;

endpackage

>>> hdl/vmifd_layout.sv
module vmifd_layout
   import vmifd_pkg::*;
(
   input  op_class_type op_class,
   input  logic [7:0]   opcode,
   input  logic [7:0]   coding,
   output layout_type   layout
);

   logic [OFF_W-1:0] cur;
   logic [1:0]       pair;
   logic [SZ_W-1:0]  sz;
   logic             stop;

   always_comb begin
      layout = '0;
      cur    = OFF_W'(2);
      stop   = 1'b0;
      pair   = PAIR_NONE;
      sz     = SZ_NONE;
      case (op_class)
         CLS_INVALID: begin
            layout.len = OFF_W'(1);
         end
         CLS_LIVE: begin
            layout.off[0] = OFF_W'(1);
            layout.sz[0]  = SZ_WORD;
            layout.len    = OFF_W'(5);
         end
         CLS_SHORT: begin
            layout.off[0] = OFF_W'(1);
            layout.sz[0]  = SZ_HALF;
            layout.len    = OFF_W'(3);
         end
         CLS_CODED: begin
            layout.type_byte = coding;
            for (int i = 0; i < NUM_PARAMS; i++) begin
               pair = coding[7-2*i -: 2];
               if (pair == PAIR_NONE) begin
                  stop = 1'b1;
               end
               if (!stop) begin
                  case (pair)
                     PAIR_REG: sz = SZ_BYTE;
                     PAIR_IND: sz = SZ_HALF;
                     default: begin
                        if ((opcode == OP_STI && cur inside {OFF_W'(3), OFF_W'(5)}) ||
                            (opcode == OP_LDI && cur inside {OFF_W'(2), OFF_W'(4)})) begin
                           sz = SZ_HALF;
                        end else begin
                           sz = SZ_WORD;
                        end
                     end
                  endcase
                  layout.off[i] = cur;
                  layout.sz[i]  = sz;
                  cur = cur + OFF_W'(sz);
               end
            end
            layout.len = cur;
         end
         default: begin
            layout.len = OFF_W'(1);
         end
      endcase
   end

endmodule

>>> hdl/vm_instruction_fetch_decode.sv
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  pc_in, window_lo, window_mid, window_hi
// rsp      out        rsp_valid / rsp_stall  opcode, valid_op, type_byte, param_*,
//                                            next_pc, clear_carry
// One request per cycle sustained while rsp_stall is low; each request passes through the stages below.
// Stages: pc wrap and opcode class, coding byte walk, operand extraction and next pc.
// Synchronous active-high reset clears the stage valid bits only.
// A stage moves when it is empty or the stage after it moves; req_stall is the
// inverse of the first stage moving, so a stall drops and repeats nothing.
module vm_instruction_fetch_decode
   import vmifd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_pc_in,
   input  logic [63:0]         req_window_lo,
   input  logic [63:0]         req_window_mid,
   input  logic [15:0]         req_window_hi,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_opcode,
   output logic                rsp_valid_op,
   output logic [7:0]          rsp_type_byte,
   output logic [31:0]         rsp_param_zero,
   output logic [31:0]         rsp_param_one,
   output logic [31:0]         rsp_param_two,
   output logic [31:0]         rsp_param_three,
   output logic [PC_W-1:0]     rsp_next_pc,
   output logic                rsp_clear_carry
);

   function automatic logic [7:0] win_byte(input logic [WIN_W-1:0] win,
                                           input logic [OFF_W-1:0] idx);
      logic [7:0] b;
      b = '0;
      for (int k = 0; k < WIN_BYTES; k++) begin
         if (idx == OFF_W'(k)) begin
            b = win[WIN_W-8-8*k +: 8];
         end
      end
      return b;
   endfunction

   function automatic logic [31:0] param_at(input logic [WIN_W-1:0] win,
                                            input logic [OFF_W-1:0] off,
                                            input logic [SZ_W-1:0]  sz);
      logic [7:0]  b0, b1, b2, b3;
      logic [31:0] v;
      b0 = win_byte(win, off);
      b1 = win_byte(win, off + OFF_W'(1));
      b2 = win_byte(win, off + OFF_W'(2));
      b3 = win_byte(win, off + OFF_W'(3));
      case (sz)
         SZ_BYTE: v = {24'd0, b0};
         SZ_HALF: v = {16'd0, b0, b1};
         SZ_WORD: v = {b0, b1, b2, b3};
         default: v = '0;
      endcase
      return v;
   endfunction

   logic en1, en2, en3;
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;

   // stage 1
   logic [PC_W-1:0]  pc1_ff;
   logic [WIN_W-1:0] win1_ff;
   logic [7:0]       op1_ff;
   op_class_type     cls1_ff, cls1_in;
   logic [7:0]       req_op;

   // stage 2
   logic [PC_W-1:0]  pc2_ff;
   logic [WIN_W-1:0] win2_ff;
   logic [7:0]       op2_ff;
   logic             valid2_ff;
   layout_type       layout2_ff, layout2_in;

   // stage 3
   logic [7:0]       op3_ff;
   logic             valid3_ff;
   logic [7:0]       type3_ff;
   logic [31:0]      p0_ff, p1_ff, p2_ff, p3_ff;
   logic [PC_W-1:0]  npc3_ff, npc3_in;

   assign en3 = !v3_ff || !rsp_stall;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1;

   assign v1_in = en1 ? req_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   assign req_op = req_window_lo[63:56];

   always_comb begin
      if (!(req_op inside {[OP_LIVE:OP_LAST]})) begin
         cls1_in = CLS_INVALID;
      end else if (req_op == OP_LIVE) begin
         cls1_in = CLS_LIVE;
      end else if (req_op inside {OP_ZJMP, OP_FORK, OP_LFORK}) begin
         cls1_in = CLS_SHORT;
      end else begin
         cls1_in = CLS_CODED;
      end
   end

   // true modulo of a power-of-two arena is the low bits of two's complement
   always_ff @(posedge clock) begin
      if (en1) begin
         pc1_ff  <= req_pc_in[PC_W-1:0];
         win1_ff <= {req_window_lo, req_window_mid, req_window_hi};
         op1_ff  <= req_op;
         cls1_ff <= cls1_in;
      end
   end

   vmifd_layout u_layout (
      .op_class (cls1_ff),
      .opcode   (op1_ff),
      .coding   (win1_ff[WIN_W-9 -: 8]),
      .layout   (layout2_in)
   );

   always_ff @(posedge clock) begin
      if (en2) begin
         pc2_ff     <= pc1_ff;
         win2_ff    <= win1_ff;
         op2_ff     <= op1_ff;
         valid2_ff  <= (cls1_ff != CLS_INVALID);
         layout2_ff <= layout2_in;
      end
   end

   assign npc3_in = pc2_ff + {{(PC_W-OFF_W){1'b0}}, layout2_ff.len};

   always_ff @(posedge clock) begin
      if (en3) begin
         op3_ff    <= op2_ff;
         valid3_ff <= valid2_ff;
         type3_ff  <= layout2_ff.type_byte;
         p0_ff     <= param_at(win2_ff, layout2_ff.off[0], layout2_ff.sz[0]);
         p1_ff     <= param_at(win2_ff, layout2_ff.off[1], layout2_ff.sz[1]);
         p2_ff     <= param_at(win2_ff, layout2_ff.off[2], layout2_ff.sz[2]);
         p3_ff     <= param_at(win2_ff, layout2_ff.off[3], layout2_ff.sz[3]);
         npc3_ff   <= npc3_in;
      end
   end

   assign rsp_valid       = v3_ff;
   assign rsp_opcode      = op3_ff;
   assign rsp_valid_op    = valid3_ff;
   assign rsp_type_byte   = type3_ff;
   assign rsp_param_zero  = p0_ff;
   assign rsp_param_one   = p1_ff;
   assign rsp_param_two   = p2_ff;
   assign rsp_param_three = p3_ff;
   assign rsp_next_pc     = npc3_ff;
   assign rsp_clear_carry = !valid3_ff;

`ifndef SYNTHESIS
   a_invalid_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clear_carry) |->
         (rsp_type_byte == 8'd0 && rsp_param_zero == 32'd0 && rsp_param_one == 32'd0 &&
          rsp_param_two == 32'd0 && rsp_param_three == 32'd0))
      else $error("invalid opcode produced operands");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted request missing from first stage");

   a_mid_held: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && v3_ff && rsp_stall) |=> v2_ff)
      else $error("stage two dropped under stall");

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && rsp_stall) |-> req_stall)
      else $error("request taken while pipeline full and stalled");
`endif

endmodule

>>> tb/sv/vm_instruction_fetch_decode_test.sv
module vm_instruction_fetch_decode_test
   import vmifd_pkg::*;
();

   localparam logic [7:0] OP_LLDI = 8'd14;
   localparam int NUM_RANDOM     = 1200;
   localparam int QUIET_TAIL     = 150;
   localparam int HOLD_AT        = 400;
   localparam int HOLD_CYCLES    = 80;

   typedef struct packed {
      logic [7:0]             opcode;
      logic                   valid_op;
      logic [7:0]             type_byte;
      logic [3:0][31:0]       params;
      logic [PC_W-1:0]        next_pc;
      logic                   clear_carry;
   } fetch_decode_type;

   class decode_scoreboard;
      fetch_decode_type pending_decodes[$];
      int errors;
      int checked;
      int invalid_seen;

      function logic [7:0] window_byte(logic [143:0] win, int k);
         if (k < 18)
            return win[143 - 8 * k -: 8];
         return 8'h00;
      endfunction

      function logic [31:0] window_field(logic [143:0] win, int off, int n);
         logic [31:0] v;
         v = '0;
         for (int k = 0; k < n; k++)
            v = {v[23:0], window_byte(win, off + k)};
         return v;
      endfunction

      function fetch_decode_type decode_fetch(logic signed [31:0] pc, logic [63:0] lo,
                                              logic [63:0] mid, logic [15:0] hi);
         logic [143:0]     win;
         longint           wrapped;
         int               off;
         int               sz;
         int               len;
         logic [7:0]       walk;
         fetch_decode_type r;
         win = {lo, mid, hi};
         wrapped = longint'(pc) % ARENA_BYTES;
         if (wrapped < 0)
            wrapped += ARENA_BYTES;
         r = '0;
         r.opcode = window_byte(win, 0);
         r.valid_op = (r.opcode >= 8'd1) && (r.opcode <= OP_LAST);
         if (!r.valid_op) begin
            len = 1;
            r.clear_carry = 1'b1;
         end else if (r.opcode == OP_LIVE) begin
            r.params[0] = window_field(win, 1, 4);
            len = 5;
         end else if (r.opcode == OP_ZJMP || r.opcode == OP_FORK || r.opcode == OP_LFORK) begin
            r.params[0] = window_field(win, 1, 2);
            len = 3;
         end else begin
            r.type_byte = window_byte(win, 1);
            walk = r.type_byte;
            off = 2;
            for (int i = 0; i < 4 && walk[7:6] != PAIR_NONE; i++) begin
               case (walk[7:6])
                  PAIR_REG: sz = 1;
                  PAIR_IND: sz = 2;
                  default: begin
                     if ((r.opcode == OP_STI && (off == 3 || off == 5)) ||
                         (r.opcode == OP_LDI && (off == 2 || off == 4)))
                        sz = 2;
                     else
                        sz = 4;
                  end
               endcase
               r.params[i] = window_field(win, off, sz);
               off += sz;
               walk = walk << 2;
            end
            len = off;
         end
         r.next_pc = PC_W'((wrapped + len) % ARENA_BYTES);
         return r;
      endfunction

      function void note_fetch(logic signed [31:0] pc, logic [63:0] lo,
                               logic [63:0] mid, logic [15:0] hi);
         fetch_decode_type r;
         r = decode_fetch(pc, lo, mid, hi);
         if (!r.valid_op)
            invalid_seen++;
         pending_decodes.push_back(r);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("decode check %0d: %s got %h want %h", checked, what, got, want);
      endtask

      task check_decode(fetch_decode_type got);
         fetch_decode_type want;
         if (pending_decodes.size() == 0) begin
            report_mismatch("response with nothing pending, opcode", 32'(got.opcode), 32'd0);
            return;
         end
         want = pending_decodes.pop_front();
         checked++;
         if (got.opcode !== want.opcode)
            report_mismatch("opcode", 32'(got.opcode), 32'(want.opcode));
         if (got.valid_op !== want.valid_op)
            report_mismatch("valid_op", 32'(got.valid_op), 32'(want.valid_op));
         if (got.type_byte !== want.type_byte)
            report_mismatch("type_byte", 32'(got.type_byte), 32'(want.type_byte));
         for (int i = 0; i < 4; i++)
            if (got.params[i] !== want.params[i])
               report_mismatch($sformatf("param %0d", i), got.params[i], want.params[i]);
         if (got.next_pc !== want.next_pc)
            report_mismatch("next_pc", 32'(got.next_pc), 32'(want.next_pc));
         if (got.clear_carry !== want.clear_carry)
            report_mismatch("clear_carry", 32'(got.clear_carry), 32'(want.clear_carry));
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic signed [31:0]  req_pc_in = '0;
   logic [63:0]         req_window_lo = '0;
   logic [63:0]         req_window_mid = '0;
   logic [15:0]         req_window_hi = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [7:0]          rsp_opcode;
   logic                rsp_valid_op;
   logic [7:0]          rsp_type_byte;
   logic [31:0]         rsp_param_zero;
   logic [31:0]         rsp_param_one;
   logic [31:0]         rsp_param_two;
   logic [31:0]         rsp_param_three;
   logic [PC_W-1:0]     rsp_next_pc;
   logic                rsp_clear_carry;

   decode_scoreboard sb = new;
   bit quiet = 1'b0;
   bit hold_req = 1'b0;
   bit holding = 1'b0;
   int held_off_cycles = 0;

   logic signed [31:0] pc_edges [8] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1,
                                        32'sd4095, 32'sd4096, -32'sd4096, -32'sd4097};

   always #2 clock = ~clock;

   vm_instruction_fetch_decode u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pc_in       (req_pc_in),
      .req_window_lo   (req_window_lo),
      .req_window_mid  (req_window_mid),
      .req_window_hi   (req_window_hi),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_opcode      (rsp_opcode),
      .rsp_valid_op    (rsp_valid_op),
      .rsp_type_byte   (rsp_type_byte),
      .rsp_param_zero  (rsp_param_zero),
      .rsp_param_one   (rsp_param_one),
      .rsp_param_two   (rsp_param_two),
      .rsp_param_three (rsp_param_three),
      .rsp_next_pc     (rsp_next_pc),
      .rsp_clear_carry (rsp_clear_carry)
   );

   always @(posedge clock) begin : rsp_monitor
      fetch_decode_type got;
      if (!reset && req_valid && req_stall)
         held_off_cycles++;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.opcode = rsp_opcode;
         got.valid_op = rsp_valid_op;
         got.type_byte = rsp_type_byte;
         got.params = {rsp_param_three, rsp_param_two, rsp_param_one, rsp_param_zero};
         got.next_pc = rsp_next_pc;
         got.clear_carry = rsp_clear_carry;
         sb.check_decode(got);
      end
   end

   task send_fetch(logic signed [31:0] pc, logic [63:0] lo, logic [63:0] mid,
                   logic [15:0] hi);
      @(negedge clock);
      req_valid <= 1'b1;
      req_pc_in <= pc;
      req_window_lo <= lo;
      req_window_mid <= mid;
      req_window_hi <= hi;
      do
         @(posedge clock);
      while (req_stall);
      sb.note_fetch(pc, lo, mid, hi);
   endtask

   task send_op(logic signed [31:0] pc, logic [7:0] op, logic [7:0] coding);
      logic [63:0] fill;
      fill = {$urandom, $urandom};
      send_fetch(pc, {op, coding, fill[47:0]}, {$urandom, $urandom}, 16'($urandom));
   endtask

   task idle_sender(int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // receiver: random stall bursts, one long hold-off on request
   initial begin : rsp_side
      int n;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (hold_req && !holding) begin
            holding = 1'b1;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
            hold_req = 1'b0;
            holding = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            n = $urandom_range(1, 20);
            repeat (n) begin
               @(negedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin : watchdog
      #2000000;
      $display("vm_instruction_fetch_decode: mismatch");
      $finish;
   end

   initial begin : stimulus
      logic signed [31:0] pc;
      logic [7:0]         op;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int k = 0; k <= 17; k++)
         send_op(pc_edges[k % 8], 8'(k), 8'($urandom));
      send_op(pc_edges[0], 8'hFF, 8'hFF);
      send_op(pc_edges[1], OP_LDI, 8'hA4);   // two short directs, then a register
      send_op(pc_edges[2], OP_STI, 8'h68);   // register, then two short directs
      send_op(pc_edges[3], OP_LLDI, 8'hAA);  // lldi keeps full-width directs
      send_op(pc_edges[4], OP_LDI, 8'hFF);
      send_op(pc_edges[5], OP_STI, 8'h00);
      send_op(pc_edges[6], OP_STI, 8'h4C);   // walk stops at the first empty pair

      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == HOLD_AT)
            hold_req = 1'b1;
         if (n == NUM_RANDOM - QUIET_TAIL)
            quiet = 1'b1;
         pc = ($urandom_range(0, 7) == 0) ? pc_edges[$urandom_range(0, 7)] : $urandom;
         op = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 16));
         send_op(pc, op, 8'($urandom));
         if (!quiet && !hold_req && !holding && $urandom_range(0, 4) == 0)
            idle_sender($urandom_range(1, 12));
      end
      idle_sender(1);

      while (sb.pending_decodes.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);

      $display("covered %0d decodes, %0d with invalid opcodes, all opcodes and pc extremes",
               sb.checked, sb.invalid_seen);
      $display("requests held off for %0d cycles under response back-pressure",
               held_off_cycles);
      if (sb.errors == 0)
         $display("vm_instruction_fetch_decode: match");
      else
         $display("vm_instruction_fetch_decode: mismatch");
      $finish;
   end

endmodule
